FILE: src/address_range_claim_table_assert.svh
// Assertion macros shared by the address range claim table RTL.
`ifndef ADDRESS_RANGE_CLAIM_TABLE_ASSERT_SVH
`define ADDRESS_RANGE_CLAIM_TABLE_ASSERT_SVH

`ifndef SYNTH
// Checked on every rising edge of clk_i, disabled while rst_ni is low.
`define ARCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("address_range_claim_table: assertion failed");
`define ARCT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define ARCT_ASSERT(lbl, prop)
`define ARCT_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

FILE: src/arct_pkg.sv
// Shared types and constants of the address range claim table.
`timescale 1ns / 1ps

package arct_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register select is address bit 2 (registers at byte 0 and byte 4).
  localparam logic REG_RSV_START = 1'b0;
  localparam logic REG_RSV_END   = 1'b1;

  localparam logic [3:0] CLAIM_ARGS   = 4'd3;
  localparam logic [3:0] CLAIM_RETS   = 4'd1;
  localparam logic [3:0] RELEASE_ARGS = 4'd2;
  localparam logic [3:0] RELEASE_RETS = 4'd0;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic {
    ACT_CLAIM   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } slot_t;

  typedef struct packed {
    action_e           action;
    logic [3:0]        arg_count;
    logic [3:0]        ret_count;
    logic [DATA_W-1:0] range_base;
    logic [DATA_W-1:0] range_size;
    logic [DATA_W-1:0] alignment;
  } req_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    slot_t             data;
  } wr_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] granted_base;
  } res_t;

endpackage

FILE: src/arct_slot_mem.sv
// Slot memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module arct_slot_mem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [arct_pkg::IDX_W-1:0] rd_addr_i,
  output arct_pkg::slot_t       rd_data_o,
  input  arct_pkg::wr_t         wr_i
);
  import arct_pkg::*;

  slot_t            mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  slot_t            rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // An entry never written since reset reads as a free slot of all zeros.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: src/arct_scan.sv
// Request sequencer: checks a request, scans the slot memory and writes back.
`timescale 1ns / 1ps

module arct_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  arct_pkg::req_t             req_i,
  input  logic [arct_pkg::DATA_W-1:0] rsv_start_i,
  input  logic [arct_pkg::DATA_W-1:0] rsv_end_i,
  output logic                       idle_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output arct_pkg::res_t             res_o,
  output logic                       rd_en_o,
  output logic [arct_pkg::IDX_W-1:0] rd_addr_o,
  input  arct_pkg::slot_t            rd_data_i,
  output arct_pkg::wr_t              wr_o
);
  import arct_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic              have_free_q, have_free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  action_e           action_q, action_d;
  logic [DATA_W-1:0] base_q, base_d;
  logic [DATA_W-1:0] rend_q, rend_d;
  logic              status_q, status_d;
  logic [DATA_W-1:0] granted_q, granted_d;

  logic [DATA_W-1:0] req_end;
  logic              shape_ok;
  logic              in_rsv;
  logic              last;
  logic              hit;
  logic              free_now;

  assign req_end = req_i.range_base + req_i.range_size;
  assign in_rsv  = (req_i.range_base >= rsv_start_i) && (req_end < rsv_end_i);
  assign last    = (chk_idx_q == IDX_W'(SLOTS - 1));

  always_comb begin
    unique case (req_i.action)
      ACT_CLAIM: shape_ok = (req_i.arg_count == CLAIM_ARGS) &&
                            (req_i.ret_count == CLAIM_RETS) &&
                            (req_i.alignment == '0);
      ACT_RELEASE: shape_ok = (req_i.arg_count == RELEASE_ARGS) &&
                              (req_i.ret_count == RELEASE_RETS);
      default: shape_ok = 1'b0;
    endcase
  end

  // Overlap test of the claim against one stored entry, or exact match on release.
  always_comb begin
    free_now = (rd_data_i.hi == '0);
    if (action_q == ACT_CLAIM) begin
      hit = !free_now &&
            (((base_q >= rd_data_i.lo) && (base_q < rd_data_i.hi)) ||
             ((rend_q >= rd_data_i.lo) && (rend_q < rd_data_i.hi)));
    end else begin
      hit = (rd_data_i.lo == base_q) && (rd_data_i.hi == rend_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    action_d    = action_q;
    base_d      = base_q;
    rend_d      = rend_q;
    status_d    = status_q;
    granted_d   = granted_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = cnt_q[IDX_W-1:0];
    wr_o        = '0;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          action_d    = req_i.action;
          base_d      = req_i.range_base;
          rend_d      = req_end;
          cnt_d       = '0;
          have_free_d = 1'b0;
          if (shape_ok && !in_rsv) begin
            state_d = ST_SCAN;
          end else begin
            status_d  = STATUS_FAIL;
            granted_d = '0;
            state_d   = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q < CNT_W'(SLOTS)) begin
          rd_en_o   = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_q[IDX_W-1:0];
        end
        if (chk_vld_q) begin
          if (action_q == ACT_CLAIM) begin
            if (free_now && !have_free_q) begin
              have_free_d = 1'b1;
              free_idx_d  = chk_idx_q;
            end
            if (hit) begin
              status_d  = STATUS_FAIL;
              granted_d = '0;
              state_d   = ST_DONE;
            end else if (last) begin
              state_d = ST_DONE;
              if (have_free_q || free_now) begin
                wr_o.en      = 1'b1;
                wr_o.addr    = have_free_q ? free_idx_q : chk_idx_q;
                wr_o.data.lo = base_q;
                wr_o.data.hi = rend_q;
                status_d     = STATUS_OK;
                granted_d    = base_q;
              end else begin
                status_d  = STATUS_FAIL;
                granted_d = '0;
              end
            end
          end else begin
            if (hit) begin
              wr_o.en   = 1'b1;
              wr_o.addr = chk_idx_q;
              status_d  = STATUS_OK;
              granted_d = '0;
              state_d   = ST_DONE;
            end else if (last) begin
              status_d  = STATUS_FAIL;
              granted_d = '0;
              state_d   = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    have_free_q <= have_free_d;
    free_idx_q  <= free_idx_d;
    action_q    <= action_d;
    base_q      <= base_d;
    rend_q      <= rend_d;
    status_q    <= status_d;
    granted_q   <= granted_d;
  end

  assign res_o.status       = status_q;
  assign res_o.granted_base = granted_q;

endmodule

FILE: src/address_range_claim_table.sv
// Top level of the address range claim table.
// Usage:
//   Requests enter on the s_ channel: s_tuser_i carries the action (claim or
//   release), s_tdata_i the call shape and the range. One result per request
//   leaves on the m_ channel: m_tuser_o is the status, m_tdata_o the base
//   granted by a successful claim (zero otherwise).
//   Requests are handled one at a time. A request that passes its checks
//   reads the slots through the single read port of the slot memory, one
//   slot per cycle. The next request is not accepted until the result of
//   the current one has moved into the output register behind m_tvalid_o.
//   A claim stops its scan at the first overlap and a release at its match.
//   A request refused by its checks skips the scan and goes straight to
//   the done state, from which its result moves to the output register.
//   A new request is accepted as soon as the previous result sits in the
//   output register, even if the receiver has not yet taken it.
//   When the receiver stalls with a result held, a finished scan waits and
//   no further request is accepted.
//   Reset clears the control and configuration registers and marks every
//   slot free at once; the block is idle and ready for a request as soon
//   as reset is released.
`timescale 1ns / 1ps
`include "address_range_claim_table_assert.svh"

module address_range_claim_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // s_tdata_i: arg_count[3:0], ret_count[7:4], range_base[39:8],
  //            range_size[71:40], alignment[103:72]
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [103:0]                s_tdata_i,
  // s_tuser_i: action[0]
  input  logic                        s_tuser_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  // m_tdata_o: granted_base[31:0]
  output logic [arct_pkg::DATA_W-1:0] m_tdata_o,
  // m_tuser_o: status[0]
  output logic                        m_tuser_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arct_pkg::ADDR_W-1:0] paddr,
  input  logic [arct_pkg::DATA_W-1:0] pwdata,
  output logic [arct_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import arct_pkg::*;

  logic [DATA_W-1:0] rsv_start_q, rsv_end_q;
  logic              m_valid_q;
  res_t              m_res_q;

  req_t              req;
  res_t              res;
  logic              idle;
  logic              res_valid;
  logic              res_ready;
  logic              start;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  slot_t             rd_data;
  wr_t               wr;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_start_q <= '0;
      rsv_end_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RSV_START: rsv_start_q <= pwdata;
        REG_RSV_END:   rsv_end_q   <= pwdata;
        default:       rsv_start_q <= rsv_start_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RSV_START: prdata = rsv_start_q;
      REG_RSV_END:   prdata = rsv_end_q;
      default:       prdata = '0;
    endcase
  end

  assign req.action     = action_e'(s_tuser_i);
  assign req.arg_count  = s_tdata_i[3:0];
  assign req.ret_count  = s_tdata_i[7:4];
  assign req.range_base = s_tdata_i[39:8];
  assign req.range_size = s_tdata_i[71:40];
  assign req.alignment  = s_tdata_i[103:72];

  assign s_tready_o = idle;
  assign start      = s_tvalid_i && idle;
  assign res_ready  = !m_valid_q || m_tready_i;

  arct_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .rsv_start_i (rsv_start_q),
    .rsv_end_i   (rsv_end_q),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_o        (wr)
  );

  arct_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // Output register decouples the finished result from the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_res_q.granted_base;
  assign m_tuser_o  = m_res_q.status;

  `ARCT_ASSERT_MSG(a_one_at_a_time, (s_tvalid_i && s_tready_o) |=> !s_tready_o,
    "second request accepted while one is in flight")
  `ARCT_ASSERT_MSG(a_fail_no_base, (m_tvalid_o && (m_tuser_o == STATUS_FAIL)) |->
    (m_tdata_o == '0), "failed request reports a nonzero base")
  `ARCT_ASSERT_MSG(a_write_busy, wr.en |-> (!idle && !res_valid),
    "slot memory written outside of a scan")
  `ARCT_ASSERT(a_read_busy, rd_en |-> !idle)

endmodule
